@@ src/icv_pkg.sv @@
package icv_pkg;

   localparam int KERNEL_SIZE = 3;
   localparam int TAP_N       = KERNEL_SIZE * KERNEL_SIZE;

   localparam int PIX_W     = 8;
   localparam int COEF_W    = 16;
   localparam int COEF_ROW_W = KERNEL_SIZE * COEF_W;
   localparam int DIM_W     = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = COEF_ROW_W;

   // Nine products of an 8-bit pixel and a Q8.8 coefficient stay below 2^27.
   localparam int ACC_W = 28;
   // Nine Q8.8 coefficients stay below 2^19 in magnitude.
   localparam int SUM_W = 20;
   localparam int DD_W  = 19;
   localparam int REM_W = 29;
   localparam int TAP_CNT_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_MODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd6;

   localparam logic BORDER_COPY = 1'b0;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FETCH = 6'b000010,
      ST_PREP  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

@@ src/image_convolution_3x3.sv @@
// 3x3 correlation filter on a raster stream of 8-bit grey pixels with signed Q8.8
// coefficients, edge copy or edge replication, optional division by the coefficient
// sum, and rounding with saturation to 0..255. Result k of a frame comes out with
// input pixel k+W+1; after the last pixel of a frame, drain words of any mode
// release the remaining W+1 results, the last one marked with frame_end. A word
// that makes a result stalls the input after it is taken: the fetch state reads
// the nine taps through the single read port of the line store and accumulates
// their products, then the prepare state sets up the operands, the check state
// rounds or saturates, and the done state loads the output register. A border
// pixel in copy mode skips the rounding step. A normalized value that is positive
// and below saturation also runs a one-bit-per-cycle divider. A configuration
// error skips the computation and gives a zero result. A finished result waits
// in the output register while the next word is taken, and a result that finishes
// while that register is still held adds the wait. Configuration must be written
// by the user only while no word is in flight; the block does not enforce this.
module image_convolution_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [icv_pkg::PIX_W-1:0]            req_pixel_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [icv_pkg::PIX_W-1:0]            rsp_pixel_out,
   output logic                                 rsp_frame_end,
   output logic                                 rsp_config_error,
   input  logic                                 csr_we,
   input  logic [icv_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [icv_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import icv_pkg::*;

   localparam int DEPTH = 2 * MAX_WIDTH + 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = AW + 2;

   // Configuration.
   logic [COEF_ROW_W-1:0] coef_ff [KERNEL_SIZE];
   logic                  border_ff;
   logic                  norm_ff;
   logic [DIM_W-1:0]      width_ff;
   logic [DIM_W-1:0]      height_ff;

   // Line store.
   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [AW-1:0]    rd_addr;

   // Control.
   state_type        state_ff, state_in;
   logic [DIM_W-1:0] in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [DIM_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [DIM_W:0]   lin_ff, lin_in;
   logic [AW-1:0]    wptr_ff, wptr_in, optr_ff, optr_in;
   logic             frame_full_ff, frame_full_in;
   logic [AW-1:0]    base_ff, base_in;
   logic             top_ff, top_in, bot_ff, bot_in, left_ff, left_in, right_ff, right_in;
   logic             copy_ff, copy_in, last_ff, last_in, err_ff, err_in;
   logic [TAP_CNT_W-1:0] tap_cnt_ff, tap_cnt_in;
   logic [1:0]       ti_ff, ti_in, tj_ff, tj_in, mi_ff, mi_in, mj_ff, mj_in;
   logic             mac_vld_ff, mac_vld_in;
   logic [2:0]       div_bit_ff, div_bit_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Datapath.
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [PIX_W-1:0]        center_ff, center_in;
   logic signed [REM_W-1:0] num_ff, num_in;
   logic [DD_W-1:0]         dd_ff, dd_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [PIX_W-1:0]        quo_ff, quo_in, res_ff, res_in;
   logic [PIX_W-1:0]        rsp_pix_ff, rsp_pix_in;
   logic                    rsp_end_ff, rsp_end_in, rsp_err_ff, rsp_err_in;

   logic signed [SUM_W-1:0]  coef_sum;
   logic                     cfg_bad;
   logic                     take;
   logic signed [COEF_W-1:0] coef_sel;
   logic signed [PIX_W+COEF_W:0] prod;
   logic signed [OW-1:0]     offs, addr_raw;
   logic signed [OW-1:0]     width_s;
   logic [REM_W-1:0]         numer, den_top, cand;
   logic [DIM_W:0]           w_ext, h_ext;

   always_comb begin
      coef_sum = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            coef_sum = coef_sum + SUM_W'($signed(coef_ff[r][c*COEF_W +: COEF_W]));
         end
      end
   end

   assign w_ext = {1'b0, width_ff};
   assign h_ext = {1'b0, height_ff};

   assign cfg_bad = (width_ff < DIM_W'(KERNEL_SIZE)) || (height_ff < DIM_W'(KERNEL_SIZE))
                 || (32'(width_ff) > MAX_WIDTH) || (32'(height_ff) > MAX_HEIGHT)
                 || (norm_ff && (coef_sum == '0));

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && !req_stall;

   // Neighbor address: the output position plus a row and column step, the steps
   // dropped where the window hangs over the image edge.
   assign width_s = $signed({2'b00, AW'(width_ff)});
   always_comb begin
      offs = '0;
      if (ti_ff == 2'd0 && !top_ff) begin
         offs = -width_s;
      end else if (ti_ff == 2'd2 && !bot_ff) begin
         offs = width_s;
      end
      if (tj_ff == 2'd0 && !left_ff) begin
         offs = offs - OW'(1);
      end else if (tj_ff == 2'd2 && !right_ff) begin
         offs = offs + OW'(1);
      end
      addr_raw = $signed({2'b00, base_ff}) + offs;
      if (addr_raw < 0) begin
         addr_raw = addr_raw + OW'(DEPTH);
      end else if (addr_raw >= OW'(DEPTH)) begin
         addr_raw = addr_raw - OW'(DEPTH);
      end
      rd_addr = addr_raw[AW-1:0];
   end

   assign coef_sel = $signed(coef_ff[mi_ff][mj_ff*COEF_W +: COEF_W]);
   assign prod     = $signed({1'b0, rd_data_ff}) * coef_sel;

   assign numer   = {num_ff[REM_W-2:0], 1'b0} + REM_W'(dd_ff);
   assign den_top = REM_W'({dd_ff, 1'b0, 8'b0});
   assign cand    = REM_W'({dd_ff, 1'b0}) << div_bit_ff;

   always_comb begin
      logic emit, ff_next, last_now;
      emit = 1'b0;
      ff_next = frame_full_ff;
      last_now = 1'b0;
      mem_we = 1'b0;
      state_in = state_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lin_in = lin_ff;
      wptr_in = wptr_ff;
      optr_in = optr_ff;
      frame_full_in = frame_full_ff;
      base_in = base_ff;
      top_in = top_ff;
      bot_in = bot_ff;
      left_in = left_ff;
      right_in = right_ff;
      copy_in = copy_ff;
      last_in = last_ff;
      err_in = err_ff;
      tap_cnt_in = tap_cnt_ff;
      ti_in = ti_ff;
      tj_in = tj_ff;
      mi_in = ti_ff;
      mj_in = tj_ff;
      mac_vld_in = 1'b0;
      div_bit_in = div_bit_ff;
      acc_in = acc_ff;
      center_in = center_ff;
      num_in = num_ff;
      dd_in = dd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in = rsp_pix_ff;
      rsp_end_in = rsp_end_ff;
      rsp_err_in = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (frame_full_ff) begin
                  emit = 1'b1;
               end else if (!req_mode) begin
                  mem_we = 1'b1;
                  emit = ({1'b0, lin_ff} >= ({1'b0, w_ext} + (DIM_W+2)'(1)));
                  if (width_ff != '0) begin
                     wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
                     if (lin_ff != '1) begin
                        lin_in = lin_ff + (DIM_W+1)'(1);
                     end
                  end
                  if (({1'b0, in_row_ff} + (DIM_W+1)'(1) >= h_ext)
                      && ({1'b0, in_col_ff} + (DIM_W+1)'(1) >= w_ext)) begin
                     ff_next = 1'b1;
                  end else if ({1'b0, in_col_ff} + (DIM_W+1)'(1) >= w_ext) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + DIM_W'(1);
                  end else begin
                     in_col_in = in_col_ff + DIM_W'(1);
                  end
               end
               if (emit) begin
                  top_in = (out_row_ff == '0);
                  bot_in = ({1'b0, out_row_ff} + (DIM_W+1)'(1) >= h_ext);
                  left_in = (out_col_ff == '0);
                  right_in = ({1'b0, out_col_ff} + (DIM_W+1)'(1) >= w_ext);
                  last_now = bot_in && right_in;
                  copy_in = (border_ff == BORDER_COPY)
                          && (top_in || bot_in || left_in || right_in);
                  base_in = optr_ff;
                  last_in = last_now;
                  err_in = cfg_bad;
                  if (last_now) begin
                     out_row_in = '0;
                     out_col_in = '0;
                     optr_in = '0;
                     if (ff_next) begin
                        ff_next = 1'b0;
                        in_row_in = '0;
                        in_col_in = '0;
                        wptr_in = '0;
                        lin_in = '0;
                     end
                  end else begin
                     if (right_in) begin
                        out_col_in = '0;
                        out_row_in = out_row_ff + DIM_W'(1);
                     end else begin
                        out_col_in = out_col_ff + DIM_W'(1);
                     end
                     if (width_ff != '0) begin
                        optr_in = (optr_ff == AW'(DEPTH - 1)) ? '0 : optr_ff + AW'(1);
                     end
                  end
                  if (cfg_bad) begin
                     res_in = '0;
                     state_in = ST_DONE;
                  end else begin
                     acc_in = '0;
                     tap_cnt_in = '0;
                     ti_in = '0;
                     tj_in = '0;
                     state_in = ST_FETCH;
                  end
               end
               frame_full_in = ff_next;
            end
         end
         ST_FETCH: begin
            // Read one tap per cycle; the product of the previous tap is accumulated.
            if (tap_cnt_ff < TAP_CNT_W'(TAP_N)) begin
               mac_vld_in = 1'b1;
               if (tj_ff == 2'd2) begin
                  tj_in = '0;
                  ti_in = ti_ff + 2'd1;
               end else begin
                  tj_in = tj_ff + 2'd1;
               end
            end
            if (mac_vld_ff) begin
               acc_in = acc_ff + ACC_W'(prod);
               if (mi_ff == 2'd1 && mj_ff == 2'd1) begin
                  center_in = rd_data_ff;
               end
            end
            if (tap_cnt_ff == TAP_CNT_W'(TAP_N)) begin
               state_in = ST_PREP;
            end else begin
               tap_cnt_in = tap_cnt_ff + TAP_CNT_W'(1);
            end
         end
         ST_PREP: begin
            if (copy_ff) begin
               res_in = center_ff;
               state_in = ST_DONE;
            end else begin
               if (norm_ff && coef_sum < 0) begin
                  num_in = -REM_W'(acc_ff);
                  dd_in = DD_W'(-coef_sum);
               end else if (norm_ff) begin
                  num_in = REM_W'(acc_ff);
                  dd_in = DD_W'(coef_sum);
               end else begin
                  num_in = REM_W'(acc_ff);
                  dd_in = DD_W'(256);
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (num_ff <= 0) begin
               res_in = '0;
               state_in = ST_DONE;
            end else if (numer >= den_top) begin
               res_in = '1;
               state_in = ST_DONE;
            end else if (!norm_ff) begin
               // Rounding division by 256 is a shift of the doubled numerator.
               res_in = numer[PIX_W+8:9];
               state_in = ST_DONE;
            end else begin
               rem_in = numer;
               quo_in = '0;
               div_bit_in = 3'd7;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= cand) begin
               rem_in = rem_ff - cand;
               quo_in[div_bit_ff] = 1'b1;
            end
            if (div_bit_ff == '0) begin
               res_in = quo_in;
               state_in = ST_DONE;
            end else begin
               div_bit_in = div_bit_ff - 3'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in = res_ff;
               rsp_end_in = last_ff;
               rsp_err_in = err_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wptr_ff] <= req_pixel_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= '0;
         coef_ff[1] <= COEF_ROW_W'(256);
         coef_ff[2] <= '0;
         border_ff  <= 1'b1;
         norm_ff    <= 1'b0;
         width_ff   <= DIM_W'(1024);
         height_ff  <= DIM_W'(1024);
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_ROW0:    coef_ff[0] <= csr_wdata;
            CSR_COEF_ROW1:    coef_ff[1] <= csr_wdata;
            CSR_COEF_ROW2:    coef_ff[2] <= csr_wdata;
            CSR_BORDER_MODE:  border_ff  <= csr_wdata[0];
            CSR_NORMALIZE:    norm_ff    <= csr_wdata[0];
            CSR_IMAGE_WIDTH:  width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         lin_ff        <= '0;
         wptr_ff       <= '0;
         optr_ff       <= '0;
         frame_full_ff <= 1'b0;
         mac_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         lin_ff        <= lin_in;
         wptr_ff       <= wptr_in;
         optr_ff       <= optr_in;
         frame_full_ff <= frame_full_in;
         mac_vld_ff    <= mac_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      top_ff     <= top_in;
      bot_ff     <= bot_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      copy_ff    <= copy_in;
      last_ff    <= last_in;
      err_ff     <= err_in;
      tap_cnt_ff <= tap_cnt_in;
      ti_ff      <= ti_in;
      tj_ff      <= tj_in;
      mi_ff      <= mi_in;
      mj_ff      <= mj_in;
      div_bit_ff <= div_bit_in;
      acc_ff     <= acc_in;
      center_ff  <= center_in;
      num_ff     <= num_in;
      dd_ff      <= dd_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      res_ff     <= res_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_end_ff <= rsp_end_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pix_ff;
   assign rsp_frame_end    = rsp_end_ff;
   assign rsp_config_error = rsp_err_ff;

   // A finished result waits while the output word is still held.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("result left before the output register was free");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall)) |=> rsp_valid_ff)
      else $error("finished result was not loaded into the output register");

   a_full_emits: assert property (@(posedge clock) disable iff (reset)
      (take && frame_full_ff) |=> (state_ff != ST_IDLE))
      else $error("word after a full frame did not produce a result");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_bit_ff != '0) |=> (state_ff == ST_DIV))
      else $error("divider stopped before its last quotient bit");

   a_error_fast: assert property (@(posedge clock) disable iff (reset)
      (take && frame_full_ff && cfg_bad) |=> (state_ff == ST_DONE && res_ff == '0))
      else $error("configuration error did not give a zero result");

endmodule

@@ tb/image_convolution_3x3_test.sv @@
module image_convolution_3x3_test;
   import icv_pkg::*;

   localparam int  RING_N    = 2 * 1024 + 4;
   localparam int  MAX_DIM   = 1024;
   localparam int  SETTLE_N  = 40;
   localparam int  LIMIT_N   = 4000000;
   localparam int  PHASE_N   = 460;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             fend;
      logic             err;
   } filt_result_t;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  mode;
      logic [PIX_W-1:0]      pix;
      bit                    has_exp;
      filt_result_t          exp_res;
   } stim_row_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_mode;
   logic [PIX_W-1:0]       req_pixel_in;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic                   rsp_frame_end;
   logic                   rsp_config_error;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   image_convolution_3x3 u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pixel_out(rsp_pixel_out),
      .rsp_frame_end(rsp_frame_end), .rsp_config_error(rsp_config_error),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Filter model state.
   logic [COEF_ROW_W-1:0] kern_row [3];
   logic                  border_sel;
   logic                  norm_on;
   logic [DIM_W-1:0]      img_w;
   logic [DIM_W-1:0]      img_h;
   logic [PIX_W-1:0]      ring [RING_N];
   longint                in_col, in_row, out_col, out_row;
   bit                    frame_full;

   filt_result_t          pending_pix [$];
   int                    fails = 0;
   int                    cycles = 0;
   int                    send_idle_pct;
   int                    recv_idle_pct;
   int                    words_sent;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint kern_tap(int r, int c);
      return longint'($signed(kern_row[r][16*c +: 16]));
   endfunction

   function automatic longint kern_total();
      longint s;
      s = 0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            s += kern_tap(r, c);
      return s;
   endfunction

   function automatic bit setup_bad();
      if (img_w < 3 || img_h < 3 || img_w > MAX_DIM || img_h > MAX_DIM) return 1'b1;
      return norm_on && kern_total() == 0;
   endfunction

   function automatic logic [PIX_W-1:0] ring_read(longint rr, longint cc);
      longint w, h;
      w = img_w;
      h = img_h;
      if (rr < 0) rr = 0;
      if (rr > h - 1) rr = h - 1;
      if (cc < 0) cc = 0;
      if (cc > w - 1) cc = w - 1;
      return ring[(rr * w + cc) % RING_N];
   endfunction

   function automatic logic [PIX_W-1:0] round_clip(longint num, longint den);
      longint q;
      if (num <= 0) return '0;
      q = (2 * num + den) / (2 * den);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   task automatic emit_filtered(output filt_result_t res);
      longint w, h, acc, s;
      logic [PIX_W-1:0] win [9];
      bit last, edge_px;
      w = img_w;
      h = img_h;
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res = '0;
      res.err = setup_bad();
      res.fend = last;
      if (!res.err) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               win[i*3+j] = ring_read(out_row + i - 1, out_col + j - 1);
         edge_px = out_row == 0 || out_col == 0 || out_row + 1 >= h || out_col + 1 >= w;
         if (border_sel == BORDER_COPY && edge_px) begin
            res.pix = win[4];
         end else begin
            acc = 0;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  acc += longint'(win[i*3+j]) * kern_tap(i, j);
            if (norm_on) begin
               s = kern_total();
               if (s < 0) begin
                  s = -s;
                  acc = -acc;
               end
               res.pix = round_clip(acc, s);
            end else begin
               res.pix = round_clip(acc, 256);
            end
         end
      end
      if (last) begin
         out_row = 0;
         out_col = 0;
         if (frame_full) begin
            frame_full = 0;
            in_row = 0;
            in_col = 0;
         end
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   // Advances the model by one accepted word; returns whether it makes a result.
   task automatic filter_word(input logic m, input logic [PIX_W-1:0] p,
                              output bit made, output filt_result_t res);
      longint w, h, lin;
      w = img_w;
      h = img_h;
      made = 0;
      res = '0;
      if (frame_full) begin
         emit_filtered(res);
         made = 1;
      end else if (!m) begin
         lin = in_row * w + in_col;
         ring[lin % RING_N] = p;
         if (in_row + 1 >= h && in_col + 1 >= w) begin
            frame_full = 1;
         end else if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
         if (lin >= w + 1) begin
            emit_filtered(res);
            made = 1;
         end
      end
   endtask

   task automatic push_word(input logic m, input logic [PIX_W-1:0] p,
                            input bit has_exp, input filt_result_t exp_res);
      bit made;
      filt_result_t res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_pixel_in <= p;
      do @(posedge clock); while (req_stall);
      filter_word(m, p, made, res);
      if (made) pending_pix.push_back(has_exp ? exp_res : res);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pix.size() != 0) @(negedge clock);
      repeat (SETTLE_N) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_COEF_ROW0:    kern_row[0] = data;
         CSR_COEF_ROW1:    kern_row[1] = data;
         CSR_COEF_ROW2:    kern_row[2] = data;
         CSR_BORDER_MODE:  border_sel = data[0];
         CSR_NORMALIZE:    norm_on = data[0];
         CSR_IMAGE_WIDTH:  img_w = data[DIM_W-1:0];
         CSR_IMAGE_HEIGHT: img_h = data[DIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [COEF_W-1:0] pick_tap();
      case ($urandom_range(3))
         0: return COEF_W'($urandom);
         1: return COEF_W'($urandom_range(512));
         2: return -COEF_W'($urandom_range(256));
         default: return '0;
      endcase
   endfunction

   task automatic random_setup();
      logic [CSR_DATA_W-1:0] row;
      int w, h, pick;
      wait_idle();
      pick = $urandom_range(99);
      w = $urandom_range(3, 8);
      h = $urandom_range(3, 8);
      if (pick < 8) begin
         w = $urandom_range(0, 2);
         h = $urandom_range(0, 5);
      end else if (pick < 14) begin
         h = $urandom_range(0, 2);
      end
      for (int r = 0; r < 3; r++) begin
         row = {pick_tap(), pick_tap(), pick_tap()};
         if ($urandom_range(9) == 0) row = '0;
         write_reg(CSR_IDX_W'(r), row);
      end
      write_reg(CSR_BORDER_MODE, CSR_DATA_W'($urandom_range(1)));
      write_reg(CSR_NORMALIZE, CSR_DATA_W'($urandom_range(1)));
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      csr_we <= 1'b0;
   endtask

   task automatic random_frame();
      int guard;
      guard = 0;
      if ($urandom_range(7) == 0) push_word(1'b1, PIX_W'($urandom), 0, '0);
      while (!frame_full && guard < 5000) begin
         push_word(1'b0, PIX_W'($urandom), 0, '0);
         guard++;
      end
      // Pixels during the drain are ignored, so they mix in as noise.
      while (frame_full)
         push_word($urandom_range(3) != 0, PIX_W'($urandom), 0, '0);
   endtask

   stim_row_t rows [$];

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      stim_row_t r;
      r = '{default: '0};
      r.is_csr = 1;
      r.idx = idx;
      r.data = d;
      rows.push_back(r);
   endtask

   task automatic add_word(input logic m, input logic [PIX_W-1:0] p, input bit has_exp,
                           input filt_result_t e);
      stim_row_t r;
      r = '{default: '0};
      r.mode = m;
      r.pix = p;
      r.has_exp = has_exp;
      r.exp_res = e;
      rows.push_back(r);
   endtask

   always @(negedge clock)
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      filt_result_t want;
      cycles <= cycles + 1;
      if (cycles > LIMIT_N) begin
         $display("image_convolution_3x3 test failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pix.size() == 0) begin
            $display("%0t: unexpected word pix=%0d fe=%0b err=%0b", $time,
                     rsp_pixel_out, rsp_frame_end, rsp_config_error);
            fails++;
         end else begin
            want = pending_pix.pop_front();
            if (want.pix !== rsp_pixel_out || want.fend !== rsp_frame_end ||
                want.err !== rsp_config_error) begin
               $display("%0t: expected pix=%0d fe=%0b err=%0b, got pix=%0d fe=%0b err=%0b",
                        $time, want.pix, want.fend, want.err, rsp_pixel_out,
                        rsp_frame_end, rsp_config_error);
               fails++;
            end
         end
      end
   end

   initial begin
      filt_result_t e0, e1;
      int phase_start;
      bit in_csr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_pixel_in = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      words_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      kern_row[0] = '0;
      kern_row[1] = 48'd256;
      kern_row[2] = '0;
      border_sel = 1'b1;
      norm_on = 1'b0;
      img_w = 11'd1024;
      img_h = 11'd1024;
      foreach (ring[i]) ring[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_full = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A 2x2 frame is too small for the kernel: every result flags the error.
      e0 = '{pix: '0, fend: 1'b0, err: 1'b1};
      e1 = '{pix: '0, fend: 1'b1, err: 1'b1};
      add_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(2));
      add_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(2));
      add_word(1'b1, 8'h00, 0, '0);
      add_word(1'b0, 8'h00, 0, '0);
      add_word(1'b0, 8'hFF, 0, '0);
      add_word(1'b0, 8'h80, 0, '0);
      add_word(1'b0, 8'hFF, 1, e0);
      add_word(1'b1, 8'h00, 1, e0);
      add_word(1'b0, 8'h55, 1, e0);
      add_word(1'b1, 8'h00, 1, e1);
      // Smallest legal frame with copy border, normalize and extreme coefficients.
      add_csr(CSR_COEF_ROW0, 48'h7FFF_0100_8000);
      add_csr(CSR_COEF_ROW1, 48'hFFFF_0400_0001);
      add_csr(CSR_COEF_ROW2, 48'h0000_FF00_0200);
      add_csr(CSR_BORDER_MODE, CSR_DATA_W'(0));
      add_csr(CSR_NORMALIZE, CSR_DATA_W'(1));
      add_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(3));
      add_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3));
      add_word(1'b0, 8'd0, 0, '0);
      add_word(1'b0, 8'd255, 0, '0);
      add_word(1'b0, 8'd1, 0, '0);
      add_word(1'b0, 8'd128, 0, '0);
      add_word(1'b0, 8'd255, 0, '0);
      add_word(1'b0, 8'd0, 0, '0);
      add_word(1'b0, 8'd254, 0, '0);
      add_word(1'b0, 8'd255, 0, '0);
      add_word(1'b0, 8'd0, 0, '0);
      repeat (4) add_word(1'b1, 8'd0, 0, '0);

      in_csr = 0;
      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            if (!in_csr) wait_idle();
            in_csr = 1;
            write_reg(rows[i].idx, rows[i].data);
         end else begin
            if (in_csr) csr_we <= 1'b0;
            in_csr = 0;
            push_word(rows[i].mode, rows[i].pix, rows[i].has_exp, rows[i].exp_res);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 79 : 0;
         recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 7 : 0;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_N) begin
            random_setup();
            random_frame();
         end
      end

      req_valid <= 1'b0;
      while (pending_pix.size() != 0) @(negedge clock);
      repeat (SETTLE_N) @(negedge clock);
      if (fails == 0 && pending_pix.size() == 0) begin
         $display("image_convolution_3x3 test passed");
      end else begin
         $display("image_convolution_3x3 test failed");
      end
      $finish;
   end

endmodule
